>>> src/fmau_pkg.sv
// ----------------------------------------------------------------------------
// fmau_pkg
// Shared types, constants and helper functions of the fused multiply-add unit.
// ----------------------------------------------------------------------------
package fmau_pkg;

   localparam int EXP_W = 14;
   typedef logic signed [EXP_W-1:0] exp_type;

   localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] QNAN_GEN  = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] INF_BITS  = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] MAX_DBL   = 64'h7FEF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MAX_SGL   = 64'h47EF_FFFF_E000_0000;
   localparam logic [63:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;
   localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;

   localparam exp_type SCALE_DBL = 14'sd1536;
   localparam exp_type SCALE_SGL = 14'sd192;
   localparam exp_type EMIN_DBL  = -14'sd1022;
   localparam exp_type EMIN_SGL  = -14'sd126;
   localparam exp_type EMAX_DBL  = 14'sd1023;
   localparam exp_type EMAX_SGL  = 14'sd127;
   localparam exp_type BIAS_DBL  = 14'sd1023;

   // request kinds; the fourth code behaves as fused multiply-add
   localparam logic [1:0] KIND_ADD = 2'd0;
   localparam logic [1:0] KIND_MUL = 2'd1;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUND_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNDERFLOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERFLOW   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NON_IEEE   = 2'd3;

   typedef enum logic [1:0] {
      RM_NEAREST = 2'd0,
      RM_ZERO    = 2'd1,
      RM_POS     = 2'd2,
      RM_NEG     = 2'd3
   } rmode_type;

   typedef enum logic [2:0] {
      CL_ZERO,
      CL_FIN,
      CL_INF,
      CL_QNAN,
      CL_SNAN
   } cls_type;

   typedef struct packed {
      rmode_type rm;
      logic      ue;
      logic      oe;
      logic      nie;
   } cfg_type;

   typedef struct packed {
      cls_type     cls;
      logic        s;
      exp_type     e;
      logic [52:0] sig;
   } opnd_type;

   // fields that ride along the whole pipe
   typedef struct packed {
      logic        fixed;
      logic [63:0] fixed_bits;
      logic        snan;
      logic        isi;
      logic        imz;
      logic        sgl;
      logic        neg_res;
   } meta_type;

   typedef struct packed {
      meta_type    meta;
      logic        prod_zero;
      logic        add_active;
      logic        ps;
      exp_type     pe;
      logic [52:0] sa;
      logic [52:0] sc;
      logic        b_s;
      exp_type     b_e;
      logic [52:0] b_sig;
   } s1_type;

   typedef struct packed {
      meta_type    meta;
      logic        prod_zero;
      logic        add_active;
      logic        ps;
      exp_type     pe;
      logic [53:0] pp_ll;
      logic [52:0] pp_lh;
      logic [52:0] pp_hl;
      logic [51:0] pp_hh;
      logic        b_s;
      exp_type     b_e;
      logic [52:0] b_sig;
   } s2_type;

   typedef struct packed {
      meta_type     meta;
      logic         add_active;
      logic         sign;
      exp_type      exp;
      logic [127:0] acc;
      logic         b_s;
      exp_type      b_e;
      logic [52:0]  b_sig;
   } s3_type;

   typedef struct packed {
      meta_type     meta;
      logic         add_active;
      logic         sign;
      logic         b_s;
      exp_type      exp;
      logic [127:0] acc;
      logic [127:0] bacc;
      logic         jam;
   } s4_type;

   typedef struct packed {
      meta_type     meta;
      logic         sub_path;
      logic         sign;
      exp_type      exp;
      logic [127:0] acc;
      logic         jam;
   } s5_type;

   typedef struct packed {
      meta_type    meta;
      logic        sign;
      exp_type     exp;
      logic [63:0] sig;
      logic        sticky;
   } s6_type;

   typedef struct packed {
      meta_type    meta;
      logic        sign;
      exp_type     exp;
      logic [52:0] kept;
      logic        inc;
      logic        inx;
      logic        tiny;
      logic        ux_scaled;
   } r1_type;

   typedef struct packed {
      meta_type    meta;
      logic        sign;
      exp_type     expf;
      logic [63:0] nsig;
      logic        xx;
      logic        fr;
      logic        ox;
      logic        ux;
   } r2_type;

   typedef struct packed {
      logic [63:0] bits;
      logic        xx;
      logic        fr;
      logic        ox;
      logic        ux;
      logic        snan;
      logic        isi;
      logic        imz;
   } rsp_type;

   function automatic logic [7:0] clz128(input logic [127:0] v);
      logic [7:0] n;
      logic       found;
      n     = 8'd128;
      found = 1'b0;
      for (int i = 127; i >= 0; i--) begin
         if (!found && v[i]) begin
            found = 1'b1;
            n     = 8'(127 - i);
         end
      end
      return n;
   endfunction

   function automatic logic [6:0] clz64(input logic [63:0] v);
      logic [6:0] n;
      logic       found;
      n     = 7'd64;
      found = 1'b0;
      for (int i = 63; i >= 0; i--) begin
         if (!found && v[i]) begin
            found = 1'b1;
            n     = 7'(63 - i);
         end
      end
      return n;
   endfunction

   // classify and normalize one double operand
   function automatic opnd_type unpack(input logic [63:0] f);
      opnd_type    u;
      logic [10:0] ef;
      logic [51:0] frac;
      logic [5:0]  lz;
      logic        found;
      ef    = f[62:52];
      frac  = 52'(f & FRAC_MASK);
      u.s   = f[63];
      u.e   = '0;
      u.sig = '0;
      u.cls = CL_ZERO;
      lz    = '0;
      found = 1'b0;
      for (int i = 51; i >= 0; i--) begin
         if (!found && frac[i]) begin
            found = 1'b1;
            lz    = 6'(51 - i);
         end
      end
      if (ef == 11'h7FF) begin
         if (frac == '0) u.cls = CL_INF;
         else if (frac[51]) u.cls = CL_QNAN;
         else u.cls = CL_SNAN;
      end else if (ef == '0) begin
         if (frac != '0) begin
            u.cls = CL_FIN;
            u.sig = {frac, 1'b0} << lz;
            u.e   = -14'sd1023 - exp_type'({8'b0, lz});
         end
      end else begin
         u.cls = CL_FIN;
         u.sig = {1'b1, frac};
         u.e   = exp_type'({3'b0, ef}) - BIAS_DBL;
      end
      return u;
   endfunction

endpackage

>>> src/fmau_unpack.sv
// ----------------------------------------------------------------------------
// fmau_unpack
// Operand select, classification, special-case results; first pipe stage.
// ----------------------------------------------------------------------------
module fmau_unpack (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  fmau_pkg::cfg_type  cfg,
   input  logic               in_valid,
   input  logic [1:0]         kind,
   input  logic [63:0]        op_a,
   input  logic [63:0]        op_c,
   input  logic [63:0]        op_b,
   input  logic               neg_add,
   input  logic               neg_res,
   input  logic               sgl,
   output logic               out_valid,
   output fmau_pkg::s1_type   out_stage
);

   logic               valid_ff;
   fmau_pkg::s1_type   stage_ff, stage_in;
   fmau_pkg::opnd_type ua, uc, ub;
   logic [63:0]        fc, fbe;
   logic               has_add, imz, ps, prod_zero, zs;
   logic               a_nan, b_nan, c_nan;

   always_comb begin
      fc      = (kind == fmau_pkg::KIND_ADD) ? fmau_pkg::ONE_BITS : op_c;
      has_add = (kind != fmau_pkg::KIND_MUL);
      fbe     = (has_add && neg_add) ? (op_b ^ fmau_pkg::SIGN_BIT) : op_b;
      ua      = fmau_pkg::unpack(op_a);
      uc      = fmau_pkg::unpack(fc);
      ub      = fmau_pkg::unpack(fbe);
      a_nan   = (ua.cls == fmau_pkg::CL_QNAN) || (ua.cls == fmau_pkg::CL_SNAN);
      b_nan   = has_add && ((ub.cls == fmau_pkg::CL_QNAN) || (ub.cls == fmau_pkg::CL_SNAN));
      c_nan   = (uc.cls == fmau_pkg::CL_QNAN) || (uc.cls == fmau_pkg::CL_SNAN);
      imz     = ((ua.cls == fmau_pkg::CL_INF) && (uc.cls == fmau_pkg::CL_ZERO)) ||
                ((ua.cls == fmau_pkg::CL_ZERO) && (uc.cls == fmau_pkg::CL_INF));
      ps        = ua.s ^ uc.s;
      prod_zero = (ua.cls == fmau_pkg::CL_ZERO) || (uc.cls == fmau_pkg::CL_ZERO);
      zs        = (!has_add || (ps == ub.s)) ? ps : (cfg.rm == fmau_pkg::RM_NEG);

      stage_in                 = '0;
      stage_in.meta.snan       = (ua.cls == fmau_pkg::CL_SNAN) || (uc.cls == fmau_pkg::CL_SNAN) ||
                                 (has_add && (ub.cls == fmau_pkg::CL_SNAN));
      stage_in.meta.imz        = imz;
      stage_in.meta.sgl        = sgl;
      stage_in.meta.neg_res    = neg_res;
      stage_in.meta.fixed      = 1'b1;

      priority if (a_nan) begin
         stage_in.meta.fixed_bits = op_a | fmau_pkg::QUIET_BIT;
      end else if (b_nan) begin
         stage_in.meta.fixed_bits = op_b | fmau_pkg::QUIET_BIT;
      end else if (c_nan) begin
         stage_in.meta.fixed_bits = fc | fmau_pkg::QUIET_BIT;
      end else if (imz) begin
         stage_in.meta.fixed_bits = fmau_pkg::QNAN_GEN;
      end else if ((ua.cls == fmau_pkg::CL_INF) || (uc.cls == fmau_pkg::CL_INF)) begin
         if (has_add && (ub.cls == fmau_pkg::CL_INF) && (ub.s != ps)) begin
            stage_in.meta.isi        = 1'b1;
            stage_in.meta.fixed_bits = fmau_pkg::QNAN_GEN;
         end else begin
            stage_in.meta.fixed_bits = {ps ^ neg_res, fmau_pkg::INF_BITS[62:0]};
         end
      end else if (has_add && (ub.cls == fmau_pkg::CL_INF)) begin
         stage_in.meta.fixed_bits = {ub.s ^ neg_res, fmau_pkg::INF_BITS[62:0]};
      end else if (prod_zero && (!has_add || (ub.cls == fmau_pkg::CL_ZERO))) begin
         stage_in.meta.fixed_bits = {zs ^ neg_res, 63'b0};
      end else begin
         stage_in.meta.fixed = 1'b0;
      end

      stage_in.prod_zero  = prod_zero;
      stage_in.add_active = has_add && (ub.cls != fmau_pkg::CL_ZERO) && !prod_zero;
      stage_in.ps         = ps;
      stage_in.pe         = ua.e + uc.e;
      stage_in.sa         = ua.sig;
      stage_in.sc         = uc.sig;
      stage_in.b_s        = ub.s;
      stage_in.b_e        = ub.e;
      stage_in.b_sig      = ub.sig;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

>>> src/fmau_mul.sv
// ----------------------------------------------------------------------------
// fmau_mul
// 53x53 significand product: partial products, then sum and 1-bit normalize;
// a zero product passes the addend on instead.
module fmau_mul (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  fmau_pkg::s1_type in_stage,
   output logic             out_valid,
   output fmau_pkg::s3_type out_stage
);

   logic              v2_ff, v3_ff;
   fmau_pkg::s2_type  s2_ff, s2_in;
   fmau_pkg::s3_type  s3_ff, s3_in;
   logic [105:0]      prod;
   fmau_pkg::exp_type pe;

   // partial products, each at most 27x27
   always_comb begin
      s2_in.meta       = in_stage.meta;
      s2_in.prod_zero  = in_stage.prod_zero;
      s2_in.add_active = in_stage.add_active;
      s2_in.ps         = in_stage.ps;
      s2_in.pe         = in_stage.pe;
      s2_in.b_s        = in_stage.b_s;
      s2_in.b_e        = in_stage.b_e;
      s2_in.b_sig      = in_stage.b_sig;
      s2_in.pp_ll      = in_stage.sa[26:0] * in_stage.sc[26:0];
      s2_in.pp_lh      = in_stage.sa[26:0] * in_stage.sc[52:27];
      s2_in.pp_hl      = in_stage.sa[52:27] * in_stage.sc[26:0];
      s2_in.pp_hh      = in_stage.sa[52:27] * in_stage.sc[52:27];
   end

   always_comb begin
      prod = 106'(s2_ff.pp_ll) + (106'(s2_ff.pp_lh) << 27) +
             (106'(s2_ff.pp_hl) << 27) + (106'(s2_ff.pp_hh) << 54);
      pe   = s2_ff.pe;
      s3_in.meta       = s2_ff.meta;
      s3_in.add_active = s2_ff.add_active;
      s3_in.b_s        = s2_ff.b_s;
      s3_in.b_e        = s2_ff.b_e;
      s3_in.b_sig      = s2_ff.b_sig;
      if (s2_ff.prod_zero) begin
         s3_in.acc  = {s2_ff.b_sig, 75'b0};
         s3_in.exp  = s2_ff.b_e;
         s3_in.sign = s2_ff.b_s;
      end else if (prod[105]) begin
         s3_in.acc  = {prod, 22'b0};
         s3_in.exp  = pe + 14'sd1;
         s3_in.sign = s2_ff.ps;
      end else begin
         s3_in.acc  = {prod[104:0], 23'b0};
         s3_in.exp  = pe;
         s3_in.sign = s2_ff.ps;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= in_valid;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_stage = s3_ff;

endmodule

>>> src/fmau_addnorm.sv
// ----------------------------------------------------------------------------
// fmau_addnorm
// Alignment of the smaller-exponent side with sticky jam, add or subtract, leading-zero normalize.
// ----------------------------------------------------------------------------
module fmau_addnorm (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  fmau_pkg::cfg_type cfg,
   input  logic              in_valid,
   input  fmau_pkg::s3_type  in_stage,
   output logic              out_valid,
   output fmau_pkg::s6_type  out_stage
);

   logic              v4_ff, v5_ff, v6_ff;
   fmau_pkg::s4_type  s4_ff, s4_in;
   fmau_pkg::s5_type  s5_ff, s5_in;
   fmau_pkg::s6_type  s6_ff, s6_in;

   logic signed [14:0] d;
   logic [14:0]        mag;
   logic [7:0]         n;
   logic [127:0]       bacc0, sh_src, sh_res, sh_mask;
   logic [128:0]       sum, diff1;
   logic [127:0]       diff2;
   logic [7:0]         lz;
   logic [127:0]       nacc;
   fmau_pkg::exp_type  e3, e5;

   // alignment: shift the smaller-exponent side right, jamming lost bits
   always_comb begin
      e3    = in_stage.exp;
      d     = {e3[13], e3} - {in_stage.b_e[13], in_stage.b_e};
      mag   = (d < 0) ? 15'(-d) : 15'(d);
      n     = (mag >= 15'd128) ? 8'd128 : mag[7:0];
      bacc0 = {in_stage.b_sig, 75'b0};
      sh_src  = (d > 0) ? bacc0 : in_stage.acc;
      sh_res  = (n[7]) ? '0 : (sh_src >> n);
      sh_mask = (n[7]) ? '1 : ~('1 << n);

      s4_in.meta       = in_stage.meta;
      s4_in.add_active = in_stage.add_active;
      s4_in.sign       = in_stage.sign;
      s4_in.b_s        = in_stage.b_s;
      s4_in.exp        = e3;
      s4_in.acc        = in_stage.acc;
      s4_in.bacc       = bacc0;
      s4_in.jam        = 1'b0;
      if (in_stage.add_active && (d != 0)) begin
         s4_in.jam = |(sh_src & sh_mask);
         if (d > 0) begin
            s4_in.bacc = sh_res;
         end else begin
            s4_in.acc = sh_res;
            s4_in.exp = in_stage.b_e;
         end
      end
   end

   always_comb begin
      sum   = {1'b0, s4_ff.acc} + {1'b0, s4_ff.bacc};
      diff1 = {1'b0, s4_ff.acc} - {1'b0, s4_ff.bacc};
      diff2 = s4_ff.bacc - s4_ff.acc;
      e5    = s4_ff.exp;

      s5_in.meta     = s4_ff.meta;
      s5_in.sub_path = 1'b0;
      s5_in.sign     = s4_ff.sign;
      s5_in.exp      = e5;
      s5_in.acc      = s4_ff.acc;
      s5_in.jam      = s4_ff.jam;
      if (s4_ff.add_active) begin
         if (s4_ff.sign == s4_ff.b_s) begin
            if (sum[128]) begin
               s5_in.acc = sum[128:1];
               s5_in.jam = s4_ff.jam | sum[0];
               s5_in.exp = e5 + 14'sd1;
            end else begin
               s5_in.acc = sum[127:0];
            end
         end else begin
            s5_in.sub_path = 1'b1;
            if (diff1[128] || (diff1[127:0] == '0)) begin
               s5_in.acc  = diff2;
               s5_in.sign = s4_ff.b_s;
            end else begin
               s5_in.acc = diff1[127:0];
            end
         end
      end
   end

   always_comb begin
      lz   = fmau_pkg::clz128(s5_ff.acc);
      nacc = s5_ff.acc << lz;
      s6_in.meta   = s5_ff.meta;
      s6_in.sign   = s5_ff.sign ^ s5_ff.meta.neg_res;
      s6_in.exp    = s5_ff.exp - fmau_pkg::exp_type'({6'b0, lz});
      s6_in.sig    = nacc[127:64];
      s6_in.sticky = s5_ff.jam | (|nacc[63:0]);
      // exact cancellation
      if (!s5_ff.meta.fixed && s5_ff.sub_path && (s5_ff.acc == '0) && !s5_ff.jam) begin
         s6_in.meta.fixed      = 1'b1;
         s6_in.meta.fixed_bits = {(cfg.rm == fmau_pkg::RM_NEG) ^ s5_ff.meta.neg_res, 63'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= in_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_stage = s6_ff;

endmodule

>>> src/fmau_round.sv
// ----------------------------------------------------------------------------
// fmau_round
// Denormalize or scale, round, overflow handling, flush and double-format pack.
// ----------------------------------------------------------------------------
module fmau_round (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  fmau_pkg::cfg_type cfg,
   input  logic              in_valid,
   input  fmau_pkg::s6_type  in_stage,
   output logic              out_valid,
   output fmau_pkg::rsp_type out_rsp
);

   logic              v7_ff, v8_ff, v9_ff;
   fmau_pkg::r1_type  r1_ff, r1_in;
   fmau_pkg::r2_type  r2_ff, r2_in;
   fmau_pkg::rsp_type rsp_ff, rsp_in;

   fmau_pkg::exp_type e6, emin6, sh, scale6;
   logic [63:0]       sig, lost_mask;
   logic              sticky, lsb, g, r, x, inx6;

   fmau_pkg::exp_type e7, emax7, scale7, er, pm1;
   logic [53:0]       k1;
   logic [52:0]       k2;
   logic              carry, ovf, to_inf, live7;
   logic [6:0]        lzk;

   fmau_pkg::exp_type ef, emin8, shp;
   logic [63:0]       packed_bits, den;
   logic [10:0]       bexp;

   // stage 7: tiny handling and round decision
   always_comb begin
      e6     = in_stage.exp;
      emin6  = in_stage.meta.sgl ? fmau_pkg::EMIN_SGL : fmau_pkg::EMIN_DBL;
      scale6 = in_stage.meta.sgl ? fmau_pkg::SCALE_SGL : fmau_pkg::SCALE_DBL;
      sh     = emin6 - e6;
      sig    = in_stage.sig;
      sticky = in_stage.sticky;
      lost_mask = ~('1 << sh[5:0]);
      r1_in           = '0;
      r1_in.meta      = in_stage.meta;
      r1_in.sign      = in_stage.sign;
      r1_in.tiny      = (e6 < emin6);
      r1_in.exp       = e6;
      if (e6 < emin6) begin
         if (cfg.ue) begin
            r1_in.exp       = e6 + scale6;
            r1_in.ux_scaled = 1'b1;
         end else begin
            if (sh > 14'sd63) begin
               sticky = sticky | (|sig);
               sig    = '0;
            end else begin
               sticky = sticky | (|(sig & lost_mask));
               sig    = sig >> sh[5:0];
            end
            r1_in.exp = emin6;
         end
      end
      if (in_stage.meta.sgl) begin
         lsb        = sig[40];
         g          = sig[39];
         r          = sig[38];
         x          = sticky | (|sig[37:0]);
         r1_in.kept = {29'b0, sig[63:40]};
      end else begin
         lsb        = sig[11];
         g          = sig[10];
         r          = sig[9];
         x          = sticky | (|sig[8:0]);
         r1_in.kept = sig[63:11];
      end
      inx6      = g | r | x;
      r1_in.inx = inx6;
      unique case (cfg.rm)
         fmau_pkg::RM_NEAREST: r1_in.inc = g & (r | x | lsb);
         fmau_pkg::RM_ZERO:    r1_in.inc = 1'b0;
         fmau_pkg::RM_POS:     r1_in.inc = !in_stage.sign && inx6;
         fmau_pkg::RM_NEG:     r1_in.inc = in_stage.sign && inx6;
         default:              r1_in.inc = 1'b0;
      endcase
   end

   // stage 8: increment, overflow, renormalize
   always_comb begin
      live7  = !r1_ff.meta.fixed;
      e7     = r1_ff.exp;
      emax7  = r1_ff.meta.sgl ? fmau_pkg::EMAX_SGL : fmau_pkg::EMAX_DBL;
      scale7 = r1_ff.meta.sgl ? fmau_pkg::SCALE_SGL : fmau_pkg::SCALE_DBL;
      pm1    = r1_ff.meta.sgl ? 14'sd23 : 14'sd52;
      k1     = {1'b0, r1_ff.kept} + {53'b0, r1_ff.inc};
      carry  = r1_ff.meta.sgl ? k1[24] : k1[53];
      k2     = carry ? k1[53:1] : k1[52:0];
      er     = carry ? (e7 + 14'sd1) : e7;
      ovf    = !r1_ff.tiny && (er > emax7);
      to_inf = (cfg.rm == fmau_pkg::RM_NEAREST) ||
               ((cfg.rm == fmau_pkg::RM_POS) && !r1_ff.sign) ||
               ((cfg.rm == fmau_pkg::RM_NEG) && r1_ff.sign);
      if (ovf && cfg.oe) begin
         er = er - scale7;
      end
      lzk = fmau_pkg::clz64({11'b0, k2});

      r2_in.meta = r1_ff.meta;
      r2_in.sign = r1_ff.sign;
      r2_in.nsig = {11'b0, k2} << lzk;
      r2_in.expf = er - pm1 + 14'sd63 - fmau_pkg::exp_type'({7'b0, lzk});
      r2_in.xx   = live7 & r1_ff.inx;
      r2_in.fr   = live7 & r1_ff.inc;
      r2_in.ox   = live7 & ovf;
      r2_in.ux   = live7 & (r1_ff.ux_scaled | (r1_ff.tiny && !cfg.ue && r1_ff.inx));
      if (live7) begin
         if (ovf && !cfg.oe) begin
            r2_in.xx         = 1'b1;
            r2_in.fr         = to_inf;
            r2_in.meta.fixed = 1'b1;
            if (to_inf) begin
               r2_in.meta.fixed_bits = {r1_ff.sign, fmau_pkg::INF_BITS[62:0]};
            end else if (r1_ff.meta.sgl) begin
               r2_in.meta.fixed_bits = {r1_ff.sign, fmau_pkg::MAX_SGL[62:0]};
            end else begin
               r2_in.meta.fixed_bits = {r1_ff.sign, fmau_pkg::MAX_DBL[62:0]};
            end
         end else if (k2 == '0) begin
            r2_in.meta.fixed      = 1'b1;
            r2_in.meta.fixed_bits = {r1_ff.sign, 63'b0};
         end
      end
   end

   // stage 9: flush, pack
   always_comb begin
      ef    = r2_ff.expf;
      emin8 = r2_ff.meta.sgl ? fmau_pkg::EMIN_SGL : fmau_pkg::EMIN_DBL;
      shp   = -14'sd1011 - ef;
      bexp  = 11'(ef + fmau_pkg::BIAS_DBL);
      den   = (shp > 14'sd63) ? '0 : (r2_ff.nsig >> shp[5:0]);
      if (ef < fmau_pkg::EMIN_DBL) begin
         packed_bits = {r2_ff.sign, 63'b0} | den;
      end else begin
         packed_bits = {r2_ff.sign, bexp, r2_ff.nsig[62:11]};
      end
      if (r2_ff.meta.fixed) begin
         rsp_in.bits = r2_ff.meta.fixed_bits;
      end else if (cfg.nie && (ef < emin8)) begin
         rsp_in.bits = {r2_ff.sign, 63'b0};
      end else begin
         rsp_in.bits = packed_bits;
      end
      rsp_in.xx   = r2_ff.xx;
      rsp_in.fr   = r2_ff.fr;
      rsp_in.ox   = r2_ff.ox;
      rsp_in.ux   = r2_ff.ux;
      rsp_in.snan = r2_ff.meta.snan;
      rsp_in.isi  = r2_ff.meta.isi;
      rsp_in.imz  = r2_ff.meta.imz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (adv) begin
         v7_ff <= in_valid;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r1_ff  <= r1_in;
         r2_ff  <= r2_in;
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = v9_ff;
   assign out_rsp   = rsp_ff;

endmodule

>>> src/fused_multiply_add_unit.sv
// ----------------------------------------------------------------------------
// fused_multiply_add_unit
// Double-format add, multiply and fused multiply-add with one rounding to
// double or single precision, IEEE special values and exception flags.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  req_*     in         req_valid / req_stall  kind, operands a c b, negates, single
//  rsp_*     out        rsp_valid / rsp_stall  result bits, seven flags
//  csr_*     in         csr_write_enable       csr_index, csr_write_data
//
//  Nine register stages lie between an accepted request and rsp_valid.
//  A new request is accepted every cycle while the pipe is not held; the
//  53x53 multiply (split into four partial products) and the 128-bit align /
//  add / normalize path set the stage count. Reset clears the stage valids
//  and the control registers. A stall on rsp while the last stage is full
//  holds every stage in place; req_stall follows it at once.
//
module fused_multiply_add_unit (
   input  logic        clock,
   input  logic        reset,
   // control registers
   input  logic        csr_write_enable,
   input  logic [fmau_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fmau_pkg::CSR_DAT_W-1:0] csr_write_data,
   // request
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [63:0] req_operand_a,
   input  logic [63:0] req_operand_c,
   input  logic [63:0] req_operand_b,
   input  logic        req_negate_addend,
   input  logic        req_negate_result,
   input  logic        req_single_target,
   // response
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_bits,
   output logic        rsp_flag_inexact,
   output logic        rsp_flag_fraction_rounded,
   output logic        rsp_flag_overflow,
   output logic        rsp_flag_underflow,
   output logic        rsp_flag_invalid_snan,
   output logic        rsp_flag_invalid_inf_sub,
   output logic        rsp_flag_invalid_inf_zero
);

   fmau_pkg::cfg_type  cfg_ff;
   logic               adv;
   logic               v1, v3, v6, v9;
   fmau_pkg::s1_type   s1;
   fmau_pkg::s3_type   s3;
   fmau_pkg::s6_type   s6;
   fmau_pkg::rsp_type  rsp;

   // control registers; to be written only while the pipe is empty, which the block does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{rm: fmau_pkg::RM_NEAREST, ue: 1'b0, oe: 1'b0, nie: 1'b0};
      end else if (csr_write_enable) begin
         unique case (csr_index)
            fmau_pkg::CSR_ROUND_MODE: cfg_ff.rm  <= fmau_pkg::rmode_type'(csr_write_data);
            fmau_pkg::CSR_UNDERFLOW:  cfg_ff.ue  <= csr_write_data[0];
            fmau_pkg::CSR_OVERFLOW:   cfg_ff.oe  <= csr_write_data[0];
            fmau_pkg::CSR_NON_IEEE:   cfg_ff.nie <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // the whole pipe moves together unless the last stage is full and held
   assign adv       = !v9 || !rsp_stall;
   assign req_stall = !adv;

   fmau_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .kind      (req_kind),
      .op_a      (req_operand_a),
      .op_c      (req_operand_c),
      .op_b      (req_operand_b),
      .neg_add   (req_negate_addend),
      .neg_res   (req_negate_result),
      .sgl       (req_single_target),
      .out_valid (v1),
      .out_stage (s1)
   );

   fmau_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v1),
      .in_stage  (s1),
      .out_valid (v3),
      .out_stage (s3)
   );

   fmau_addnorm u_addnorm (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg_ff),
      .in_valid  (v3),
      .in_stage  (s3),
      .out_valid (v6),
      .out_stage (s6)
   );

   fmau_round u_round (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg_ff),
      .in_valid  (v6),
      .in_stage  (s6),
      .out_valid (v9),
      .out_rsp   (rsp)
   );

   assign rsp_valid                 = v9;
   assign rsp_result_bits           = rsp.bits;
   assign rsp_flag_inexact          = rsp.xx;
   assign rsp_flag_fraction_rounded = rsp.fr;
   assign rsp_flag_overflow         = rsp.ox;
   assign rsp_flag_underflow        = rsp.ux;
   assign rsp_flag_invalid_snan     = rsp.snan;
   assign rsp_flag_invalid_inf_sub  = rsp.isi;
   assign rsp_flag_invalid_inf_zero = rsp.imz;

   // rounding up only happens on an inexact result
   a_fr_implies_inexact: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_flag_fraction_rounded || rsp_flag_inexact))
      else $error("fraction rounded without inexact");

   // untrapped overflow is always inexact
   a_ovf_inexact: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flag_overflow && !cfg_ff.oe) |-> rsp_flag_inexact)
      else $error("untrapped overflow not inexact");

   // infinity minus infinity delivers the default quiet NaN
   a_isi_qnan: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flag_invalid_inf_sub) |-> (rsp_result_bits == fmau_pkg::QNAN_GEN))
      else $error("inf-inf result not default NaN");

   // a signalling-NaN operand never brings rounding flags
   a_snan_no_round: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flag_invalid_snan) |->
         (!rsp_flag_inexact && !rsp_flag_fraction_rounded &&
          !rsp_flag_overflow && !rsp_flag_underflow))
      else $error("rounding flags on NaN result");

endmodule

>>> sim/fused_multiply_add_unit_tb.sv
// ----------------------------------------------------------------------------
// fused_multiply_add_unit_tb
// Self-checking bench for the fused multiply-add unit. A bit-exact predictor
// of add, multiply and fused multiply-add with one rounding computes the
// expected result and flags of each request. The checker compares every
// response in order. Random idle gaps fall on both channels, and the control
// registers are swept between phases while the pipe is empty.
// ----------------------------------------------------------------------------
module fused_multiply_add_unit_tb;
   import fmau_pkg::*;

   localparam logic [1:0] KIND_FMA     = 2'd2;
   localparam logic [1:0] KIND_FMA_ALT = 2'd3;   // spare kind code, acts as fma
   localparam int         PIPE_DEPTH   = 9;

   typedef struct {
      cls_type     cls;
      logic        s;
      int          e;
      logic [63:0] m;     // normalized, leading one at bit 63
   } dbl_parts_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [1:0]  csr_write_data;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_kind;
   logic [63:0] req_operand_a;
   logic [63:0] req_operand_c;
   logic [63:0] req_operand_b;
   logic        req_negate_addend;
   logic        req_negate_result;
   logic        req_single_target;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_result_bits;
   logic        rsp_flag_inexact;
   logic        rsp_flag_fraction_rounded;
   logic        rsp_flag_overflow;
   logic        rsp_flag_underflow;
   logic        rsp_flag_invalid_snan;
   logic        rsp_flag_invalid_inf_sub;
   logic        rsp_flag_invalid_inf_zero;

   // bench copy of the control registers
   rmode_type   cur_round;
   logic        cur_ue;
   logic        cur_oe;
   logic        cur_nie;

   rsp_type     expected_results[$];
   int          error_count = 0;
   int          sent_count  = 0;
   bit          no_idle     = 1'b0;

   fused_multiply_add_unit dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------
   function automatic int lead0_64(input logic [63:0] v);
      for (int i = 63; i >= 0; i--)
         if (v[i]) return 63 - i;
      return 64;
   endfunction

   function automatic int lead0_128(input logic [127:0] v);
      for (int i = 127; i >= 0; i--)
         if (v[i]) return 127 - i;
      return 128;
   endfunction

   function automatic dbl_parts_type split_double(input logic [63:0] f);
      dbl_parts_type u;
      logic [10:0]   ef;
      logic [63:0]   frac;
      int            lz;
      ef    = f[62:52];
      frac  = f & FRAC_MASK;
      u.s   = f[63];
      u.e   = 0;
      u.m   = '0;
      u.cls = CL_FIN;
      if (ef == 11'h7FF) begin
         if (frac == 0) u.cls = CL_INF;
         else if (frac[51]) u.cls = CL_QNAN;
         else u.cls = CL_SNAN;
      end else if (ef == 0) begin
         if (frac == 0) begin
            u.cls = CL_ZERO;
         end else begin
            lz  = lead0_64(frac);
            u.m = frac << lz;
            u.e = (63 - lz) - 1074;
         end
      end else begin
         u.m = (frac | (64'd1 << 52)) << 11;
         u.e = int'(ef) - 1023;
      end
      return u;
   endfunction

   // right shift, collecting the lost bits into jam
   function automatic logic [127:0] shift_jam(input logic [127:0] v, input int n,
                                              inout logic jam);
      if (n <= 0) return v;
      if (n >= 128) begin
         jam |= (v != 0);
         return '0;
      end
      jam |= ((v << (128 - n)) != 0);
      return v >> n;
   endfunction

   function automatic logic [63:0] round_and_pack(input logic sign, input int exp_in,
                                                  input logic [63:0] sig_in,
                                                  input logic sticky_in, input logic sgl,
                                                  inout rsp_type fl);
      int          p, emin, emax, scale, ex, sh;
      logic [63:0] sig, kept, nsig, sbit;
      logic        tiny, g, r, lsb, x, inx, inc, sticky, to_inf;
      p      = sgl ? 24 : 53;
      emin   = sgl ? -126 : -1022;
      emax   = sgl ? 127 : 1023;
      scale  = sgl ? 192 : 1536;
      ex     = exp_in;
      sig    = sig_in;
      sticky = sticky_in;
      sbit   = sign ? SIGN_BIT : 64'd0;
      tiny   = ex < emin;
      if (tiny) begin
         if (cur_ue) begin
            ex += scale;
            fl.ux = 1'b1;
         end else begin
            sh = emin - ex;
            if (sh >= 64) begin
               sticky |= (sig != 0);
               sig = '0;
            end else begin
               sticky |= ((sig << (64 - sh)) != 0);
               sig = sig >> sh;
            end
            ex = emin;
         end
      end
      lsb = sig[64-p];
      g   = sig[63-p];
      r   = sig[62-p];
      x   = sticky || ((sig & ((64'd1 << (62 - p)) - 64'd1)) != 0);
      inx = g || r || x;
      case (cur_round)
         RM_NEAREST: inc = g && (r || x || lsb);
         RM_ZERO:    inc = 1'b0;
         RM_POS:     inc = !sign && inx;
         default:    inc = sign && inx;
      endcase
      kept = (sig >> (64 - p)) + (inc ? 64'd1 : 64'd0);
      if ((kept >> p) != 0) begin
         kept = kept >> 1;
         ex++;
      end
      if (inx) fl.xx = 1'b1;
      if (inc) fl.fr = 1'b1;
      if (tiny && !cur_ue && inx) fl.ux = 1'b1;
      if (!tiny && ex > emax) begin
         fl.ox = 1'b1;
         if (cur_oe) begin
            ex -= scale;
         end else begin
            to_inf = cur_round == RM_NEAREST || (cur_round == RM_POS && !sign) ||
                     (cur_round == RM_NEG && sign);
            fl.xx = 1'b1;
            if (to_inf) begin
               fl.fr = 1'b1;
               return INF_BITS | sbit;
            end
            fl.fr = 1'b0;
            return sbit | (sgl ? MAX_SGL : MAX_DBL);
         end
      end
      if (kept == 0) return sbit;
      ex = ex - (p - 1) + (63 - lead0_64(kept));
      if (cur_nie && ex < emin) return sbit;
      nsig = kept << lead0_64(kept);
      if (ex < -1022) begin
         sh = -1011 - ex;
         return sbit | ((sh >= 64) ? 64'd0 : (nsig >> sh));
      end
      return sbit | (64'((ex + 1023) & 'h7FF) << 52) | ((nsig << 1) >> 12);
   endfunction

   function automatic rsp_type predict_fma(input logic [1:0] kind, input logic [63:0] fa,
                                           input logic [63:0] fc_in, input logic [63:0] fb,
                                           input logic neg_add, input logic neg_res,
                                           input logic sgl);
      rsp_type       res;
      dbl_parts_type pa, pc, pb;
      logic [63:0]   fc, fbe;
      logic [127:0]  acc, bacc;
      logic          has_add, ps, sign, jam, carry, prod_zero, zs;
      int            ex, d, lz;
      res     = '0;
      has_add = kind != KIND_MUL;
      fc      = (kind == KIND_ADD) ? ONE_BITS : fc_in;
      fbe     = (has_add && neg_add) ? (fb ^ SIGN_BIT) : fb;
      pa      = split_double(fa);
      pc      = split_double(fc);
      pb      = split_double(fbe);
      ps      = pa.s != pc.s;
      jam     = 1'b0;
      res.imz = (pa.cls == CL_INF && pc.cls == CL_ZERO) ||
                (pa.cls == CL_ZERO && pc.cls == CL_INF);
      res.snan = pa.cls == CL_SNAN || (has_add && pb.cls == CL_SNAN) || pc.cls == CL_SNAN;
      // NaN precedence a, addend, c; returned quiet and never negated
      if (pa.cls >= CL_QNAN) begin
         res.bits = fa | QUIET_BIT;
         return res;
      end
      if (has_add && pb.cls >= CL_QNAN) begin
         res.bits = fb | QUIET_BIT;
         return res;
      end
      if (pc.cls >= CL_QNAN) begin
         res.bits = fc | QUIET_BIT;
         return res;
      end
      if (res.imz) begin
         res.bits = QNAN_GEN;
         return res;
      end
      if (pa.cls == CL_INF || pc.cls == CL_INF) begin
         if (has_add && pb.cls == CL_INF && pb.s != ps) begin
            res.isi  = 1'b1;
            res.bits = QNAN_GEN;
         end else begin
            res.bits = INF_BITS | ((ps != neg_res) ? SIGN_BIT : 64'd0);
         end
         return res;
      end
      if (has_add && pb.cls == CL_INF) begin
         res.bits = INF_BITS | ((pb.s != neg_res) ? SIGN_BIT : 64'd0);
         return res;
      end
      prod_zero = pa.cls == CL_ZERO || pc.cls == CL_ZERO;
      if (prod_zero && (!has_add || pb.cls == CL_ZERO)) begin
         zs = (!has_add || ps == pb.s) ? ps : (cur_round == RM_NEG);
         res.bits = (zs != neg_res) ? SIGN_BIT : 64'd0;
         return res;
      end
      if (prod_zero) begin
         acc  = {pb.m, 64'd0};
         ex   = pb.e;
         sign = pb.s;
      end else begin
         acc = {64'd0, pa.m} * {64'd0, pc.m};
         ex  = pa.e + pc.e + 1;
         if (!acc[127]) begin
            acc = acc << 1;
            ex--;
         end
         sign = ps;
         if (has_add && pb.cls != CL_ZERO) begin
            bacc = {pb.m, 64'd0};
            d    = ex - pb.e;
            if (d > 0) begin
               bacc = shift_jam(bacc, d, jam);
            end else if (d < 0) begin
               acc = shift_jam(acc, -d, jam);
               ex  = pb.e;
            end
            if (sign == pb.s) begin
               {carry, acc} = {1'b0, acc} + {1'b0, bacc};
               if (carry) begin
                  acc      = shift_jam(acc, 1, jam);
                  acc[127] = 1'b1;
                  ex++;
               end
            end else begin
               if (bacc >= acc) begin
                  acc  = bacc - acc;
                  sign = pb.s;
               end else begin
                  acc = acc - bacc;
               end
               // exact cancellation
               if (acc == 0 && !jam) begin
                  res.bits = ((cur_round == RM_NEG) != neg_res) ? SIGN_BIT : 64'd0;
                  return res;
               end
               lz  = lead0_128(acc);
               acc = acc << lz;
               ex -= lz;
            end
         end
      end
      if (neg_res) sign = !sign;
      res.bits = round_and_pack(sign, ex, acc[127:64], jam || (acc[63:0] != 0), sgl, res);
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
      error_count++;
   endtask

   // each accepted response is checked against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected response", rsp_result_bits, 64'd0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_result_bits !== want.bits)
               report_mismatch("result_bits", rsp_result_bits, want.bits);
            if (rsp_flag_inexact !== want.xx)
               report_mismatch("flag_inexact", 64'(rsp_flag_inexact), 64'(want.xx));
            if (rsp_flag_fraction_rounded !== want.fr)
               report_mismatch("flag_fraction_rounded", 64'(rsp_flag_fraction_rounded),
                               64'(want.fr));
            if (rsp_flag_overflow !== want.ox)
               report_mismatch("flag_overflow", 64'(rsp_flag_overflow), 64'(want.ox));
            if (rsp_flag_underflow !== want.ux)
               report_mismatch("flag_underflow", 64'(rsp_flag_underflow), 64'(want.ux));
            if (rsp_flag_invalid_snan !== want.snan)
               report_mismatch("flag_invalid_snan", 64'(rsp_flag_invalid_snan),
                               64'(want.snan));
            if (rsp_flag_invalid_inf_sub !== want.isi)
               report_mismatch("flag_invalid_inf_sub", 64'(rsp_flag_invalid_inf_sub),
                               64'(want.isi));
            if (rsp_flag_invalid_inf_zero !== want.imz)
               report_mismatch("flag_invalid_inf_zero", 64'(rsp_flag_invalid_inf_zero),
                               64'(want.imz));
         end
      end
   end

   // response side back-pressure: a random hold before each response
   initial begin
      int hold;
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 9);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   // one request: random gap, then hold until accepted; prediction on accept
   task automatic send_request(input logic [1:0] kind, input logic [63:0] a,
                               input logic [63:0] c, input logic [63:0] b,
                               input logic neg_add, input logic neg_res,
                               input logic sgl);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= kind;
      req_operand_a     <= a;
      req_operand_c     <= c;
      req_operand_b     <= b;
      req_negate_addend <= neg_add;
      req_negate_result <= neg_res;
      req_single_target <= sgl;
      do @(posedge clock); while (req_stall);
      expected_results.push_back(predict_fma(kind, a, c, b, neg_add, neg_res, sgl));
      sent_count++;
      // stretches with no idling now and then
      if (sent_count % 97 == 0) no_idle = ($urandom_range(0, 3) == 0);
   endtask

   // write enable stays high; the caller drops it after the last write
   task automatic write_csr(input logic [1:0] idx, input logic [1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         CSR_ROUND_MODE: cur_round = rmode_type'(data);
         CSR_UNDERFLOW:  cur_ue    = data[0];
         CSR_OVERFLOW:   cur_oe    = data[0];
         default:        cur_nie   = data[0];
      endcase
   endtask

   // registers change only with the pipe drained
   task automatic set_config(input rmode_type rm, input logic ue, input logic oe,
                             input logic nie);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 3) @(posedge clock);
      write_csr(CSR_ROUND_MODE, rm);
      write_csr(CSR_UNDERFLOW, {1'b0, ue});
      write_csr(CSR_OVERFLOW, {1'b0, oe});
      write_csr(CSR_NON_IEEE, {1'b0, nie});
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [63:0] rand_double();
      logic [63:0] v;
      logic        s;
      logic [51:0] frac;
      s    = 1'($urandom_range(0, 1));
      frac = 52'({$urandom, $urandom});
      case ($urandom_range(0, 23))
         0:       v = {s, 63'd0};
         1:       v = {s, 11'h7FF, 52'd0};
         2:       v = {s, 11'h7FF, 1'b1, frac[50:0]};
         3:       v = {s, 11'h7FF, 1'b0, frac[50:1], 1'b1};
         4, 5:    v = {s, 11'd0, frac};
         6, 7:    v = {$urandom, $urandom};
         8, 9:    v = {s, 11'($urandom_range(1950, 2046)), frac};
         10, 11:  v = {s, 11'($urandom_range(1, 80)), frac};
         12:      v = {s, 11'($urandom_range(1, 2046)), 52'd0};
         13:      v = {s, 11'($urandom_range(1000, 1046)), frac[51:29], 29'd0};
         default: v = {s, 11'($urandom_range(900, 1150)), frac};
      endcase
      return v;
   endfunction

   // random request; many addends sit near minus the product to force
   // deep cancellation
   task automatic send_random_request();
      logic [1:0]  kind;
      logic [63:0] a, c, b;
      rsp_type     prod;
      logic        neg_add, neg_res, sgl;
      kind    = 2'($urandom_range(0, 3));
      a       = rand_double();
      c       = rand_double();
      b       = rand_double();
      neg_add = 1'($urandom_range(0, 1));
      neg_res = 1'($urandom_range(0, 1));
      sgl     = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) begin
         prod = predict_fma(KIND_MUL, a, (kind == KIND_ADD) ? ONE_BITS : c, 64'd0,
                            1'b0, 1'b0, 1'b0);
         b    = prod.bits ^ (neg_add ? 64'd0 : SIGN_BIT);
         b    = b ^ (64'($urandom_range(0, 7)) << $urandom_range(0, 40));
      end
      send_request(kind, a, c, b, neg_add, neg_res, sgl);
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_special_values();
      set_config(RM_NEAREST, 1'b0, 1'b0, 1'b0);
      send_request(KIND_ADD, ONE_BITS, 64'd0, ONE_BITS, 1'b0, 1'b0, 1'b0);
      send_request(KIND_ADD, ONE_BITS, 64'd0, ONE_BITS, 1'b1, 1'b0, 1'b0);  // 1 - 1
      send_request(KIND_ADD, ONE_BITS, 64'd0, ONE_BITS, 1'b1, 1'b1, 1'b0);
      send_request(KIND_MUL, MAX_DBL, MAX_DBL, 64'd0, 1'b0, 1'b0, 1'b0);     // overflow
      send_request(KIND_MUL, 64'd1, 64'd1, 64'd0, 1'b0, 1'b0, 1'b0);         // underflow
      send_request(KIND_FMA, INF_BITS, 64'd0, ONE_BITS, 1'b0, 1'b0, 1'b0);   // inf * 0
      send_request(KIND_FMA, INF_BITS, ONE_BITS, INF_BITS, 1'b1, 1'b0, 1'b0); // inf - inf
      send_request(KIND_FMA, INF_BITS, ONE_BITS, INF_BITS, 1'b0, 1'b1, 1'b0);
      send_request(KIND_FMA, 64'h7FF0_0000_0000_0001, QNAN_GEN, 64'hFFF8_0000_0000_0002,
                   1'b0, 1'b1, 1'b0);                                      // snan in a
      send_request(KIND_FMA, ONE_BITS, 64'h7FF0_0000_0000_0005, 64'hFFF8_0000_0000_0002,
                   1'b1, 1'b0, 1'b0);                                      // addend nan wins
      send_request(KIND_MUL, ONE_BITS, 64'h7FF0_0000_0000_0005, QNAN_GEN,
                   1'b0, 1'b0, 1'b0);                                      // nan in c
      send_request(KIND_FMA, 64'd0, INF_BITS, QNAN_GEN, 1'b0, 1'b0, 1'b0);   // nan + imz
      send_request(KIND_FMA, SIGN_BIT, ONE_BITS, SIGN_BIT, 1'b0, 1'b0, 1'b0); // -0 + -0
      send_request(KIND_FMA, SIGN_BIT, ONE_BITS, 64'd0, 1'b0, 1'b0, 1'b0);    // -0 + +0
      send_request(KIND_FMA_ALT, 64'h4008_0000_0000_0000, 64'h3FD5_5555_5555_5555,
                   ONE_BITS, 1'b1, 1'b0, 1'b0);
      send_request(KIND_ADD, 64'h3FF5_5555_5555_5555, 64'd0, 64'd0, 1'b0, 1'b0, 1'b1);
      send_request(KIND_ADD, MAX_DBL, 64'd0, MAX_DBL, 1'b0, 1'b0, 1'b1);
      send_request(KIND_MUL, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1);
      send_request(KIND_FMA, 64'h000F_FFFF_FFFF_FFFF, ONE_BITS, 64'h8000_0000_0000_0001,
                   1'b0, 1'b0, 1'b0);
      send_request(KIND_FMA, 64'h3FF0_0000_0000_0001, 64'h3FF0_0000_0000_0001,
                   64'hBFF0_0000_0000_0002, 1'b0, 1'b0, 1'b0);               // deep cancel
      send_request(KIND_MUL, 64'h0010_0000_0000_0000, 64'h3FE0_0000_0000_0000, 64'd0,
                   1'b0, 1'b0, 1'b0);
      send_request(KIND_ADD, 64'd0, 64'd0, SIGN_BIT, 1'b1, 1'b0, 1'b0);
   endtask

   task automatic test_rounding_modes();
      for (int m = 0; m < 4; m++) begin
         set_config(rmode_type'(m), 1'b0, 1'b0, 1'b0);
         repeat (250) send_random_request();
      end
   endtask

   task automatic test_exception_scaling();
      set_config(rmode_type'($urandom_range(0, 3)), 1'b1, 1'b1, 1'b0);
      repeat (250) send_random_request();
      set_config(RM_NEG, 1'b1, 1'b0, 1'b1);
      repeat (150) send_random_request();
      set_config(RM_POS, 1'b0, 1'b1, 1'b0);
      repeat (100) send_random_request();
   endtask

   task automatic test_flush_to_zero();
      set_config(RM_ZERO, 1'b0, 1'b1, 1'b1);
      repeat (100) send_random_request();
      set_config(RM_NEG, 1'b1, 1'b1, 1'b1);
      repeat (100) send_random_request();
   endtask

   initial begin
      reset             <= 1'b1;
      csr_write_enable  <= 1'b0;
      csr_index         <= CSR_ROUND_MODE;
      csr_write_data    <= 2'd0;
      req_valid         <= 1'b0;
      req_kind          <= KIND_ADD;
      req_operand_a     <= '0;
      req_operand_c     <= '0;
      req_operand_b     <= '0;
      req_negate_addend <= 1'b0;
      req_negate_result <= 1'b0;
      req_single_target <= 1'b0;
      cur_round = RM_NEAREST;
      cur_ue    = 1'b0;
      cur_oe    = 1'b0;
      cur_nie   = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_special_values();
      test_rounding_modes();
      test_exception_scaling();
      test_flush_to_zero();

      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // run limit
   initial begin
      #3200000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
